// ----- sv/fvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared widths, codes and types of the FIFO vertex cache.
// ----------------------------------------------------------------------------
package fvc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int VTX_W       = 32;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 6;
    localparam int COST_W      = 2;

    localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 6'd32;

    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_PROBE = 1'b1
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Per-slot update strobes from the sequencer.
    typedef struct packed {
        logic wr;
        logic clr;
    } t_lane_ctl;

endpackage

// ----- sv/fvc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_lane
// One cache slot: a stored tag, its valid bit and a tag comparator.
// ----------------------------------------------------------------------------
module fvc_lane (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fvc_pkg::t_lane_ctl     i_ctl,
    input  logic [fvc_pkg::VTX_W-1:0] i_key,
    output logic                   o_match
);
    import fvc_pkg::*;

    logic [VTX_W-1:0] r_tag;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_tag <= i_key;
        end
    end

    // A write to the slot that is dropped in the same cycle wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end
    end

    assign o_match = r_valid && (r_tag == i_key);

endmodule

// ----- sv/fvc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_merge
// Combines the per-slot match flags into one hit decision.
// ----------------------------------------------------------------------------
module fvc_merge #(
    parameter int ENTRIES = fvc_pkg::ENTRIES_DEF
) (
    input  logic [ENTRIES-1:0] i_match,
    output logic               o_hit
);
    import fvc_pkg::*;

    assign o_hit = |i_match;

endmodule

// ----- sv/fifo_vertex_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_vertex_cache
// FIFO post-transform vertex cache with parallel tag compare.
// ----------------------------------------------------------------------------
// One input word carries a triangle of three vertex indices. The block works
// on one triangle at a time and takes its vertices one after another, in order:
// for each vertex every slot compares its tag with the current vertex, the
// match flags are merged into a hit, and in add mode the FIFO pointers and
// the slot written or dropped are updated, so the next vertex of the same
// triangle sees that insertion. The result word is loaded into an output
// register with the third vertex; when that register still holds an untaken
// result, the third vertex waits until it is taken. A new triangle is
// accepted in the cycle after the result is loaded; the block takes no new
// triangle before it is through with the current one. Slots are a circular
// buffer with a head pointer at the oldest entry and a fill count; only
// valid bits are cleared at reset, so no clearing pass is needed. The user
// must write the cache_size register only while the block is idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module fifo_vertex_cache #(
    parameter int ENTRIES = fvc_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration.
    input  logic                        i_cfg_we,
    input  logic [fvc_pkg::CFG_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [fvc_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [fvc_pkg::VTX_W-1:0]   i_vertex_b,
    input  logic [fvc_pkg::VTX_W-1:0]   i_vertex_c,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [fvc_pkg::COST_W-1:0]  o_miss_cost,
    output logic [fvc_pkg::CNT_W-1:0]   o_hit_total,
    output logic [fvc_pkg::CNT_W-1:0]   o_miss_total
);
    import fvc_pkg::*;

    // Slot pointer, fill count and the width used to compare against the limit.
    localparam int PW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int SW   = PW + 1;
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [1:0] LAST_STEP = 2'd2;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // Registers.
    t_state            r_state,     n_state;
    logic [CFG_W-1:0]  r_cache_size;
    logic              r_kind,      n_kind;
    logic [VTX_W-1:0]  r_vtx_a,     n_vtx_a;
    logic [VTX_W-1:0]  r_vtx_b,     n_vtx_b;
    logic [VTX_W-1:0]  r_vtx_c,     n_vtx_c;
    logic [1:0]        r_step,      n_step;
    logic [COST_W-1:0] r_cost,      n_cost;
    logic [PW-1:0]     r_head,      n_head;
    logic [CW-1:0]     r_count,     n_count;
    logic [CNT_W-1:0]  r_hit_cnt,   n_hit_cnt;
    logic [CNT_W-1:0]  r_miss_cnt,  n_miss_cnt;
    logic              r_out_valid, n_out_valid;
    logic [COST_W-1:0] r_out_cost,  n_out_cost;
    logic [CNT_W-1:0]  r_out_hit,   n_out_hit;
    logic [CNT_W-1:0]  r_out_miss,  n_out_miss;

    // Datapath signals.
    logic [VTX_W-1:0]   key;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic               out_free;
    logic               step_en;
    logic               do_write;
    logic               do_drop;
    logic [CMPW-1:0]    size_ext;
    logic [CMPW-1:0]    limit;
    logic [CMPW-1:0]    count_ext;
    logic [SW-1:0]      wsum;
    logic [PW-1:0]      wslot;
    t_lane_ctl          lane_ctl [ENTRIES];

    // Vertex of the current step.
    always_comb begin
        case (r_step)
            2'd0:    key = r_vtx_a;
            2'd1:    key = r_vtx_b;
            default: key = r_vtx_c;
        endcase
    end

    // A cache_size above the built slot count acts as the slot count.
    assign size_ext  = CMPW'(r_cache_size);
    assign limit     = (size_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : size_ext;
    assign count_ext = CMPW'(r_count);

    // Next free slot is head plus count, wrapped at the slot count. When the
    // cache fills every built slot this is the head slot itself, which is dropped and
    // rewritten in the same cycle.
    always_comb begin
        wsum = SW'(r_head) + SW'(r_count);
        if (wsum >= SW'(ENTRIES)) begin
            wsum = wsum - SW'(ENTRIES);
        end
        wslot = wsum[PW-1:0];
    end

    // Slots, one comparator each.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        assign lane_ctl[g].wr  = do_write && (wslot == PW'(g));
        assign lane_ctl[g].clr = do_drop  && (r_head == PW'(g));

        fvc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[g]),
            .i_key   (key),
            .o_match (match[g])
        );
    end

    fvc_merge #(
        .ENTRIES (ENTRIES)
    ) u_merge (
        .i_match (match),
        .o_hit   (hit)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign step_en  = (r_state == ST_RUN) && ((r_step != LAST_STEP) || out_free);

    // Sequencer and FIFO bookkeeping.
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_vtx_a     = r_vtx_a;
        n_vtx_b     = r_vtx_b;
        n_vtx_c     = r_vtx_c;
        n_step      = r_step;
        n_cost      = r_cost;
        n_head      = r_head;
        n_count     = r_count;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_out_valid = r_out_valid;
        n_out_cost  = r_out_cost;
        n_out_hit   = r_out_hit;
        n_out_miss  = r_out_miss;
        do_write    = 1'b0;
        do_drop     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_vtx_a = i_vertex_a;
                    n_vtx_b = i_vertex_b;
                    n_vtx_c = i_vertex_c;
                    n_step  = 2'd0;
                    n_cost  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    if (!hit) begin
                        n_cost = r_cost + COST_W'(1);
                    end
                    if (t_kind'(r_kind) == KIND_ADD) begin
                        if (hit) begin
                            n_hit_cnt = sat_inc(r_hit_cnt);
                        end else begin
                            n_miss_cnt = sat_inc(r_miss_cnt);
                            if (count_ext >= limit) begin
                                // At or over the limit: an empty cache keeps nothing,
                                // otherwise the oldest entry makes room.
                                if (r_count != '0) begin
                                    do_drop  = 1'b1;
                                    do_write = 1'b1;
                                    n_head   = (r_head == PW'(ENTRIES - 1)) ?
                                               '0 : r_head + PW'(1);
                                end
                            end else begin
                                do_write = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                    end
                    if (r_step == LAST_STEP) begin
                        n_out_valid = 1'b1;
                        n_out_cost  = n_cost;
                        n_out_hit   = n_hit_cnt;
                        n_out_miss  = n_miss_cnt;
                        n_state     = ST_IDLE;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cache_size <= CACHE_SIZE_RST;
            r_head       <= '0;
            r_count      <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            if (i_cfg_we) begin
                r_cache_size <= i_cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_vtx_a    <= n_vtx_a;
        r_vtx_b    <= n_vtx_b;
        r_vtx_c    <= n_vtx_c;
        r_cost     <= n_cost;
        r_out_cost <= n_out_cost;
        r_out_hit  <= n_out_hit;
        r_out_miss <= n_out_miss;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_miss_cost  = r_out_cost;
    assign o_hit_total  = r_out_hit;
    assign o_miss_total = r_out_miss;

endmodule
